[hdl/rmq_pkg.sv]
package rmq_pkg;

    localparam int FRAC_BITS = 14;
    localparam int ENT_W     = 16;
    localparam int COMP_W    = 16;
    // signed width of trace and root argument
    localparam int ARG_W     = (FRAC_BITS + 2 > ENT_W + 2) ? FRAC_BITS + 2 : ENT_W + 2;
    // root width; radicand is arg << FRAC_BITS, padded to an even width
    localparam int S_W       = (ARG_W - 1 + FRAC_BITS + 1) / 2;
    localparam int V_W       = 2 * S_W;
    localparam int R_W       = S_W + 2;
    // signed width of a sum of two entries
    localparam int N_W       = ENT_W + 1;
    localparam int Q_W       = COMP_W;
    localparam int DIV_W     = N_W + FRAC_BITS + S_W + Q_W + 1;

    localparam logic [1:0] BR_TRACE = 2'd0;
    localparam logic [1:0] BR_X     = 2'd1;
    localparam logic [1:0] BR_Y     = 2'd2;
    localparam logic [1:0] BR_Z     = 2'd3;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0]                 br;
        logic                       bad;
        logic [ARG_W-2:0]           arg;
        logic [2:0][N_W-1:0]        n;
    } item_t;

    typedef struct packed {
        logic head_valid;
        logic full;
    } q_stat_t;

endpackage

[hdl/rmq_front.sv]
module rmq_front
    import rmq_pkg::*;
(
    input  logic                     in_valid,
    input  logic                     full,
    input  logic signed [ENT_W-1:0]  m00,
    input  logic signed [ENT_W-1:0]  m01,
    input  logic signed [ENT_W-1:0]  m02,
    input  logic signed [ENT_W-1:0]  m10,
    input  logic signed [ENT_W-1:0]  m11,
    input  logic signed [ENT_W-1:0]  m12,
    input  logic signed [ENT_W-1:0]  m20,
    input  logic signed [ENT_W-1:0]  m21,
    input  logic signed [ENT_W-1:0]  m22,
    output logic                     push,
    output logic                     stall,
    output item_t                    item
);

    localparam logic signed [ARG_W-1:0] ONE = ARG_W'(1) << FRAC_BITS;

    logic signed [ARG_W-1:0] d0, d1, d2, trace, arg;
    logic signed [N_W-1:0]   e01, e02, e10, e12, e20, e21;

    assign d0  = ARG_W'(m00);
    assign d1  = ARG_W'(m11);
    assign d2  = ARG_W'(m22);
    assign e01 = N_W'(m01);
    assign e02 = N_W'(m02);
    assign e10 = N_W'(m10);
    assign e12 = N_W'(m12);
    assign e20 = N_W'(m20);
    assign e21 = N_W'(m21);

    assign trace = d0 + d1 + d2;
    assign stall = full;
    assign push  = in_valid && !full;

    always_comb
    begin
        priority if (trace > 0)
        begin
            item.br   = BR_TRACE;
            arg       = ONE + trace;
            item.n[0] = e21 - e12;
            item.n[1] = e02 - e20;
            item.n[2] = e10 - e01;
        end
        else if (m00 > m11 && m00 > m22)
        begin
            item.br   = BR_X;
            arg       = ONE + d0 - d1 - d2;
            item.n[0] = e10 + e01;
            item.n[1] = e02 + e20;
            item.n[2] = e21 - e12;
        end
        else if (m11 > m22)
        begin
            item.br   = BR_Y;
            arg       = ONE + d1 - d0 - d2;
            item.n[0] = e10 + e01;
            item.n[1] = e21 + e12;
            item.n[2] = e02 - e20;
        end
        else
        begin
            item.br   = BR_Z;
            arg       = ONE + d2 - d0 - d1;
            item.n[0] = e02 + e20;
            item.n[1] = e21 + e12;
            item.n[2] = e10 - e01;
        end
        item.bad = (arg <= 0);
        item.arg = item.bad ? '0 : arg[ARG_W-2:0];
    end

endmodule

[hdl/rmq_queue.sv]
module rmq_queue
    import rmq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  item_t   push_item,
    input  logic    pop,
    output item_t   head,
    output q_stat_t stat
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    item_t              mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]     count_reg, count_next;
    logic               do_pop;

    assign do_pop          = pop && (count_reg != '0);
    assign head            = mem_reg[rd_ptr_reg];
    assign stat.head_valid = (count_reg != '0);
    assign stat.full       = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= PTR_W'(wr_ptr_reg + 1'b1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= PTR_W'(rd_ptr_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[hdl/rmq_back.sv]
module rmq_back
    import rmq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     head_valid,
    input  item_t                    head,
    output logic                     pop,
    input  logic                     out_stall,
    output logic                     out_valid,
    output logic signed [COMP_W-1:0] quat_w,
    output logic signed [COMP_W-1:0] quat_x,
    output logic signed [COMP_W-1:0] quat_y,
    output logic signed [COMP_W-1:0] quat_z,
    output logic [1:0]               branch_taken,
    output logic                     invalid_input
);

    localparam int SQ_N = S_W;
    localparam int DV_N = Q_W;
    localparam logic [Q_W-1:0] MAXP = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic [Q_W-1:0] MAXN = {1'b1, {(Q_W-1){1'b0}}};

    logic adv;

    // square root stages
    logic               sq_valid_reg [SQ_N];
    logic [R_W-1:0]     sq_rem_reg   [SQ_N];
    logic [S_W-1:0]     sq_root_reg  [SQ_N];
    logic [V_W-1:0]     sq_v_reg     [SQ_N];
    item_t              sq_item_reg  [SQ_N];

    // divider setup stage
    logic               pp_valid_reg;
    logic [S_W-1:0]     pp_s_reg;
    logic [1:0]         pp_br_reg;
    logic               pp_bad_reg;
    logic [2:0]         pp_neg_reg, pp_ovf_reg;
    logic [DIV_W-1:0]   pp_num_reg [3];

    // restoring divider stages, three lanes
    logic               dv_valid_reg [DV_N];
    logic [S_W-1:0]     dv_s_reg     [DV_N];
    logic [1:0]         dv_br_reg    [DV_N];
    logic               dv_bad_reg   [DV_N];
    logic [2:0]         dv_neg_reg   [DV_N];
    logic [2:0]         dv_ovf_reg   [DV_N];
    logic [DIV_W-1:0]   dv_rem_reg   [DV_N][3];
    logic [Q_W-1:0]     dv_q_reg     [DV_N][3];

    logic               out_valid_reg;
    logic [COMP_W-1:0]  qw_reg, qx_reg, qy_reg, qz_reg;
    logic [COMP_W-1:0]  qw_next, qx_next, qy_next, qz_next;
    logic [1:0]         br_reg;
    logic               bad_reg;

    assign adv = !out_valid_reg || !out_stall;
    assign pop = adv;

    for (genvar k = 0; k < SQ_N; k++)
    begin : g_sq
        localparam int I = SQ_N - 1 - k;
        logic [R_W-1:0]  rem_in, rem_sh, trial, rem_next;
        logic [S_W-1:0]  root_in, root_next;
        logic [V_W-1:0]  v_in;
        item_t           it_in;
        logic            vld_in, ge;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign v_in    = V_W'(head.arg) << FRAC_BITS;
            assign it_in   = head;
            assign vld_in  = head_valid;
        end
        else
        begin : g_next
            assign rem_in  = sq_rem_reg[k-1];
            assign root_in = sq_root_reg[k-1];
            assign v_in    = sq_v_reg[k-1];
            assign it_in   = sq_item_reg[k-1];
            assign vld_in  = sq_valid_reg[k-1];
        end

        assign rem_sh    = {rem_in[R_W-3:0], v_in[2*I+1 -: 2]};
        assign trial     = {root_in, 2'b01};
        assign ge        = (rem_sh >= trial);
        assign rem_next  = ge ? rem_sh - trial : rem_sh;
        assign root_next = {root_in[S_W-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_valid_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                sq_valid_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_rem_reg[k]  <= rem_next;
                sq_root_reg[k] <= root_next;
                sq_v_reg[k]    <= v_in;
                sq_item_reg[k] <= it_in;
            end
        end
    end

    // setup: magnitude, rounded numerator, overflow of the 16-bit quotient
    for (genvar l = 0; l < 3; l++)
    begin : g_pp
        logic signed [N_W-1:0] n_s;
        logic [N_W-1:0]        mag;
        logic [DIV_W-1:0]      num, den;
        logic                  ovf_next;

        assign n_s      = sq_item_reg[SQ_N-1].n[l];
        assign mag      = n_s[N_W-1] ? N_W'(-n_s) : N_W'(n_s);
        assign num      = (DIV_W'(mag) << FRAC_BITS) + DIV_W'(sq_root_reg[SQ_N-1]);
        assign den      = DIV_W'(sq_root_reg[SQ_N-1]) << 1;
        assign ovf_next = (num >= (den << Q_W));

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                pp_num_reg[l] <= num;
                pp_neg_reg[l] <= n_s[N_W-1];
                pp_ovf_reg[l] <= ovf_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pp_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            pp_valid_reg <= sq_valid_reg[SQ_N-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pp_s_reg   <= sq_root_reg[SQ_N-1];
            pp_br_reg  <= sq_item_reg[SQ_N-1].br;
            pp_bad_reg <= sq_item_reg[SQ_N-1].bad;
        end
    end

    for (genvar j = 0; j < DV_N; j++)
    begin : g_dv
        localparam int B = DV_N - 1 - j;
        logic             vld_in, bad_in;
        logic [S_W-1:0]   s_in;
        logic [1:0]       br_in;
        logic [2:0]       neg_in, ovf_in;
        logic [DIV_W-1:0] rem_in [3];
        logic [Q_W-1:0]   q_in [3];
        logic [DIV_W-1:0] dsh;

        if (j == 0)
        begin : g_first
            assign vld_in = pp_valid_reg;
            assign s_in   = pp_s_reg;
            assign br_in  = pp_br_reg;
            assign bad_in = pp_bad_reg;
            assign neg_in = pp_neg_reg;
            assign ovf_in = pp_ovf_reg;
            for (genvar l = 0; l < 3; l++)
            begin : g_l
                assign rem_in[l] = pp_num_reg[l];
                assign q_in[l]   = '0;
            end
        end
        else
        begin : g_next
            assign vld_in = dv_valid_reg[j-1];
            assign s_in   = dv_s_reg[j-1];
            assign br_in  = dv_br_reg[j-1];
            assign bad_in = dv_bad_reg[j-1];
            assign neg_in = dv_neg_reg[j-1];
            assign ovf_in = dv_ovf_reg[j-1];
            for (genvar l = 0; l < 3; l++)
            begin : g_l
                assign rem_in[l] = dv_rem_reg[j-1][l];
                assign q_in[l]   = dv_q_reg[j-1][l];
            end
        end

        assign dsh = (DIV_W'(s_in) << 1) << B;

        for (genvar l = 0; l < 3; l++)
        begin : g_lane
            logic ge;
            assign ge = (rem_in[l] >= dsh);
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    dv_rem_reg[j][l] <= ge ? rem_in[l] - dsh : rem_in[l];
                    dv_q_reg[j][l]   <= {q_in[l][Q_W-2:0], ge};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[j] <= 1'b0;
            end
            else if (adv)
            begin
                dv_valid_reg[j] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_s_reg[j]   <= s_in;
                dv_br_reg[j]  <= br_in;
                dv_bad_reg[j] <= bad_in;
                dv_neg_reg[j] <= neg_in;
                dv_ovf_reg[j] <= ovf_in;
            end
        end
    end

    // saturation and placement of components
    logic [COMP_W-1:0] lane_sat [3];
    logic [S_W:0]      root_half;
    logic [COMP_W-1:0] root_sat;

    for (genvar l = 0; l < 3; l++)
    begin : g_sat
        logic [Q_W-1:0] q;
        logic           ovf, neg;
        assign q   = dv_q_reg[DV_N-1][l];
        assign ovf = dv_ovf_reg[DV_N-1][l];
        assign neg = dv_neg_reg[DV_N-1][l];
        always_comb
        begin
            if (neg)
            begin
                lane_sat[l] = (ovf || q > MAXN) ? MAXN : COMP_W'(-q);
            end
            else
            begin
                lane_sat[l] = (ovf || q > MAXP) ? MAXP : COMP_W'(q);
            end
        end
    end

    assign root_half = ((S_W+1)'(dv_s_reg[DV_N-1]) + 1'b1) >> 1;
    assign root_sat  = (root_half > (S_W+1)'(MAXP)) ? MAXP : COMP_W'(root_half);

    always_comb
    begin
        unique case (dv_br_reg[DV_N-1])
            BR_TRACE:
            begin
                qw_next = root_sat;    qx_next = lane_sat[0];
                qy_next = lane_sat[1]; qz_next = lane_sat[2];
            end
            BR_X:
            begin
                qx_next = root_sat;    qy_next = lane_sat[0];
                qz_next = lane_sat[1]; qw_next = lane_sat[2];
            end
            BR_Y:
            begin
                qy_next = root_sat;    qx_next = lane_sat[0];
                qz_next = lane_sat[1]; qw_next = lane_sat[2];
            end
            default:
            begin
                qz_next = root_sat;    qx_next = lane_sat[0];
                qy_next = lane_sat[1]; qw_next = lane_sat[2];
            end
        endcase
        if (dv_bad_reg[DV_N-1])
        begin
            qw_next = '0; qx_next = '0; qy_next = '0; qz_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dv_valid_reg[DV_N-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            qw_reg  <= qw_next;
            qx_reg  <= qx_next;
            qy_reg  <= qy_next;
            qz_reg  <= qz_next;
            br_reg  <= dv_br_reg[DV_N-1];
            bad_reg <= dv_bad_reg[DV_N-1];
        end
    end

    assign out_valid     = out_valid_reg;
    assign quat_w        = qw_reg;
    assign quat_x        = qx_reg;
    assign quat_y        = qy_reg;
    assign quat_z        = qz_reg;
    assign branch_taken  = br_reg;
    assign invalid_input = bad_reg;

endmodule

[hdl/rotation_matrix_to_quaternion.sv]
// Pipeline from the queue head to out_valid (at Q2.14):
//   S_W square-root stages (the first loads straight from the queue head),
//   one divider setup stage, COMP_W divider stages and the output register.
// Throughput: one matrix per cycle; the root and the three quotients are fully
//   pipelined, one result bit per stage. A stalled output holds the whole back end.
// Reset (rst_n low, asynchronous): queue empty, every stage valid cleared.
module rotation_matrix_to_quaternion
    import rmq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [ENT_W-1:0]  m00,
    input  logic signed [ENT_W-1:0]  m01,
    input  logic signed [ENT_W-1:0]  m02,
    input  logic signed [ENT_W-1:0]  m10,
    input  logic signed [ENT_W-1:0]  m11,
    input  logic signed [ENT_W-1:0]  m12,
    input  logic signed [ENT_W-1:0]  m20,
    input  logic signed [ENT_W-1:0]  m21,
    input  logic signed [ENT_W-1:0]  m22,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [COMP_W-1:0] quat_w,
    output logic signed [COMP_W-1:0] quat_x,
    output logic signed [COMP_W-1:0] quat_y,
    output logic signed [COMP_W-1:0] quat_z,
    output logic [1:0]               branch_taken,
    output logic                     invalid_input
);

    // Front: picks the branch (trace or largest diagonal), forms the root
    // argument and the three off-diagonal sums/differences.
    item_t   item, head;
    q_stat_t q_stat;
    logic    push, pop;

    rmq_front u_front (
        .in_valid (in_valid),
        .full     (q_stat.full),
        .m00      (m00),
        .m01      (m01),
        .m02      (m02),
        .m10      (m10),
        .m11      (m11),
        .m12      (m12),
        .m20      (m20),
        .m21      (m21),
        .m22      (m22),
        .push     (push),
        .stall    (in_stall),
        .item     (item)
    );

    // Two-entry queue decouples input transfers from back-end stalls.
    rmq_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (item),
        .pop       (pop),
        .head      (head),
        .stat      (q_stat)
    );

    // Back: integer square root, then three restoring dividers with
    // round-half-away rounding, saturation and component placement.
    rmq_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (q_stat.head_valid),
        .head          (head),
        .pop           (pop),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .quat_w        (quat_w),
        .quat_x        (quat_x),
        .quat_y        (quat_y),
        .quat_z        (quat_z),
        .branch_taken  (branch_taken),
        .invalid_input (invalid_input)
    );

    // An invalid result carries all-zero components.
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && invalid_input |->
            quat_w == '0 && quat_x == '0 && quat_y == '0 && quat_z == '0)
        else $error("invalid result with nonzero component");

    // The trace branch has a positive argument and is never flagged.
    a_trace_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && branch_taken == BR_TRACE |-> !invalid_input)
        else $error("trace branch flagged invalid");

    // The component taken from the root is never negative.
    a_root_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !invalid_input |->
            (branch_taken == BR_TRACE && !quat_w[COMP_W-1]) ||
            (branch_taken == BR_X && !quat_x[COMP_W-1]) ||
            (branch_taken == BR_Y && !quat_y[COMP_W-1]) ||
            (branch_taken == BR_Z && !quat_z[COMP_W-1]))
        else $error("negative root component");

endmodule
